/* src/qp_pkg.sv */
// Shared codes and types for the quaternion product block.
`timescale 1ns / 1ps
package qp_pkg;

	// Element order of operands and result
	typedef enum logic {
		ORDER_XYZW = 1'b0,
		ORDER_WXYZ = 1'b1
	} order_t;

	// Product direction
	typedef enum logic {
		OP_FORWARD = 1'b0,
		OP_REVERSE = 1'b1
	} op_t;

	// Canonical component slots
	localparam int unsigned IDX_X = 0;
	localparam int unsigned IDX_Y = 1;
	localparam int unsigned IDX_Z = 2;
	localparam int unsigned IDX_W = 3;

	// One bit per product term: set where the term is subtracted
	typedef logic [3:0] neg_mask_t;

	localparam neg_mask_t NEG_X = 4'b1000;
	localparam neg_mask_t NEG_Y = 4'b0010;
	localparam neg_mask_t NEG_Z = 4'b0100;
	localparam neg_mask_t NEG_W = 4'b1110;

endpackage

/* src/qp_in_if.sv */
// Operand channel: operation code and two quaternions.
`timescale 1ns / 1ps
interface qp_in_if #(
	parameter int COEFF_WIDTH = 16
);
	logic                          valid;
	logic                          ready;
	logic                          operation;
	logic signed [COEFF_WIDTH-1:0] a_first;
	logic signed [COEFF_WIDTH-1:0] a_second;
	logic signed [COEFF_WIDTH-1:0] a_third;
	logic signed [COEFF_WIDTH-1:0] a_fourth;
	logic signed [COEFF_WIDTH-1:0] b_first;
	logic signed [COEFF_WIDTH-1:0] b_second;
	logic signed [COEFF_WIDTH-1:0] b_third;
	logic signed [COEFF_WIDTH-1:0] b_fourth;

	modport source (
		output valid, operation, a_first, a_second, a_third, a_fourth,
			b_first, b_second, b_third, b_fourth,
		input ready
	);

	modport sink (
		input valid, operation, a_first, a_second, a_third, a_fourth,
			b_first, b_second, b_third, b_fourth,
		output ready
	);
endinterface

/* src/qp_out_if.sv */
// Result channel: product quaternion and saturation flag.
`timescale 1ns / 1ps
interface qp_out_if #(
	parameter int COEFF_WIDTH = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [COEFF_WIDTH-1:0] r_first;
	logic signed [COEFF_WIDTH-1:0] r_second;
	logic signed [COEFF_WIDTH-1:0] r_third;
	logic signed [COEFF_WIDTH-1:0] r_fourth;
	logic                          saturated;

	modport source (
		output valid, r_first, r_second, r_third, r_fourth, saturated,
		input ready
	);

	modport sink (
		input valid, r_first, r_second, r_third, r_fourth, saturated,
		output ready
	);
endinterface

/* src/quaternion_product.sv */
// Top level: pipelined fixed-point Hamilton product of two quaternions.
//
// Operands arrive as one word on req: the operation (a*b or b*a) and the
// four coefficients of a and of b, signed with FRAC_BITS fraction bits.
// Results leave as one word on rsp: four coefficients in the same element
// order and a flag set when any coefficient was clipped.
// cfg_we/cfg_wdata write the element order bit (0 = x,y,z,w; 1 = w,x,y,z);
// write it only while no word is in flight.
// Five register stages: operand capture, 16 multipliers, pair sums,
// final sum with rounding, scale and saturate into the output register.
// A word accepted on req passes through these registers in order and is presented on rsp from the output register.
// Throughput is one word per cycle; the whole pipeline advances together,
// so a stalled rsp holds every stage and req.ready drops only while the
// output register is full and not being taken.
// Reset clears the stage valid bits and sets the element order to x,y,z,w.
`timescale 1ns / 1ps
module quaternion_product
	import qp_pkg::*;
#(
	parameter int COEFF_WIDTH = 16,
	parameter int FRAC_BITS   = 14
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_we,
	input  logic     cfg_wdata,
	qp_in_if.sink    req,
	qp_out_if.source rsp
);
	order_t order_q;
	logic   en;
	logic   v_s1, v_s2, v_s3, v_s4, v_s5;
	order_t order_s1, order_s2, order_s3, order_s4, order_s5;

	logic [3:0][COEFF_WIDTH-1:0] fa, fb;     // first..fourth
	logic [3:0][COEFF_WIDTH-1:0] ca, cb;     // canonical x,y,z,w
	logic [3:0][COEFF_WIDTH-1:0] a_s1, b_s1; // left and right operand
	logic [3:0][COEFF_WIDTH-1:0] lhs_x, rhs_x, lhs_y, rhs_y;
	logic [3:0][COEFF_WIDTH-1:0] lhs_z, rhs_z, lhs_w, rhs_w;
	logic signed [COEFF_WIDTH-1:0] res_x, res_y, res_z, res_w;
	logic [3:0] sat_lane;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORDER_XYZW;
		end else if (cfg_we) begin
			order_q <= order_t'(cfg_wdata);
		end
	end

	assign en        = !v_s5 || rsp.ready;
	assign req.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_comb begin
		fa[0] = req.a_first;
		fa[1] = req.a_second;
		fa[2] = req.a_third;
		fa[3] = req.a_fourth;
		fb[0] = req.b_first;
		fb[1] = req.b_second;
		fb[2] = req.b_third;
		fb[3] = req.b_fourth;
		if (order_q == ORDER_WXYZ) begin
			ca[IDX_X] = fa[1];
			ca[IDX_Y] = fa[2];
			ca[IDX_Z] = fa[3];
			ca[IDX_W] = fa[0];
			cb[IDX_X] = fb[1];
			cb[IDX_Y] = fb[2];
			cb[IDX_Z] = fb[3];
			cb[IDX_W] = fb[0];
		end else begin
			ca = fa;
			cb = fb;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (op_t'(req.operation) == OP_REVERSE) begin
				a_s1 <= cb;
				b_s1 <= ca;
			end else begin
				a_s1 <= ca;
				b_s1 <= cb;
			end
			order_s1 <= order_q;
			order_s2 <= order_s1;
			order_s3 <= order_s2;
			order_s4 <= order_s3;
			order_s5 <= order_s4;
		end
	end

	// term pairing per component of the Hamilton product
	always_comb begin
		lhs_x = {a_s1[IDX_Z], a_s1[IDX_Y], a_s1[IDX_X], a_s1[IDX_W]};
		rhs_x = {b_s1[IDX_Y], b_s1[IDX_Z], b_s1[IDX_W], b_s1[IDX_X]};
		lhs_y = {a_s1[IDX_Z], a_s1[IDX_Y], a_s1[IDX_X], a_s1[IDX_W]};
		rhs_y = {b_s1[IDX_X], b_s1[IDX_W], b_s1[IDX_Z], b_s1[IDX_Y]};
		lhs_z = {a_s1[IDX_Z], a_s1[IDX_Y], a_s1[IDX_X], a_s1[IDX_W]};
		rhs_z = {b_s1[IDX_W], b_s1[IDX_X], b_s1[IDX_Y], b_s1[IDX_Z]};
		lhs_w = {a_s1[IDX_Z], a_s1[IDX_Y], a_s1[IDX_X], a_s1[IDX_W]};
		rhs_w = {b_s1[IDX_Z], b_s1[IDX_Y], b_s1[IDX_X], b_s1[IDX_W]};
	end

	qp_lane #(.COEFF_WIDTH(COEFF_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane_x (
		.clk(clk), .en(en), .neg(NEG_X), .lhs(lhs_x), .rhs(rhs_x),
		.result(res_x), .sat(sat_lane[IDX_X])
	);

	qp_lane #(.COEFF_WIDTH(COEFF_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane_y (
		.clk(clk), .en(en), .neg(NEG_Y), .lhs(lhs_y), .rhs(rhs_y),
		.result(res_y), .sat(sat_lane[IDX_Y])
	);

	qp_lane #(.COEFF_WIDTH(COEFF_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane_z (
		.clk(clk), .en(en), .neg(NEG_Z), .lhs(lhs_z), .rhs(rhs_z),
		.result(res_z), .sat(sat_lane[IDX_Z])
	);

	qp_lane #(.COEFF_WIDTH(COEFF_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane_w (
		.clk(clk), .en(en), .neg(NEG_W), .lhs(lhs_w), .rhs(rhs_w),
		.result(res_w), .sat(sat_lane[IDX_W])
	);

	assign rsp.valid     = v_s5;
	assign rsp.saturated = |sat_lane;

	always_comb begin
		if (order_s5 == ORDER_WXYZ) begin
			rsp.r_first  = res_w;
			rsp.r_second = res_x;
			rsp.r_third  = res_y;
			rsp.r_fourth = res_z;
		end else begin
			rsp.r_first  = res_x;
			rsp.r_second = res_y;
			rsp.r_third  = res_z;
			rsp.r_fourth = res_w;
		end
	end
endmodule

/* src/qp_lane.sv */
// One result coefficient: four products, signed sum, round, scale, saturate.
`timescale 1ns / 1ps
module qp_lane
	import qp_pkg::*;
#(
	parameter int COEFF_WIDTH = 16,
	parameter int FRAC_BITS   = 14
) (
	input  logic                          clk,
	input  logic                          en,
	input  neg_mask_t                     neg,
	input  logic [3:0][COEFF_WIDTH-1:0]   lhs,
	input  logic [3:0][COEFF_WIDTH-1:0]   rhs,
	output logic signed [COEFF_WIDTH-1:0] result,
	output logic                          sat
);
	localparam int PROD_W = 2 * COEFF_WIDTH;
	// sum of four products needs two extra bits; the rounding term needs FRAC_BITS+1
	localparam int SUM_W  = (PROD_W + 2 > FRAC_BITS + 1) ? PROD_W + 2 : FRAC_BITS + 1;

	localparam logic signed [SUM_W-1:0] HI =
		{{(SUM_W - COEFF_WIDTH + 1){1'b0}}, {(COEFF_WIDTH - 1){1'b1}}};
	localparam logic signed [SUM_W-1:0] LO =
		{{(SUM_W - COEFF_WIDTH + 1){1'b1}}, {(COEFF_WIDTH - 1){1'b0}}};
	localparam logic signed [SUM_W-1:0] HALF =
		{{(SUM_W - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};

	logic signed [PROD_W-1:0] prod_s2 [4];
	logic signed [SUM_W-1:0]  term    [4];
	logic signed [SUM_W-1:0]  pair_s3 [2];
	logic signed [SUM_W-1:0]  total_s4;
	logic signed [SUM_W-1:0]  scaled;
	logic signed [COEFF_WIDTH-1:0] result_s5;
	logic                          sat_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				prod_s2[i] <= $signed(lhs[i]) * $signed(rhs[i]);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			term[i] = SUM_W'(prod_s2[i]);
			if (neg[i]) begin
				term[i] = -term[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pair_s3[0] <= term[0] + term[1];
			pair_s3[1] <= term[2] + term[3];
		end
	end

	// round half up, then floor
	always_ff @(posedge clk) begin
		if (en) begin
			total_s4 <= pair_s3[0] + pair_s3[1] + HALF;
		end
	end

	assign scaled = total_s4 >>> FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en) begin
			if (scaled > HI) begin
				result_s5 <= HI[COEFF_WIDTH-1:0];
				sat_s5    <= 1'b1;
			end else if (scaled < LO) begin
				result_s5 <= LO[COEFF_WIDTH-1:0];
				sat_s5    <= 1'b1;
			end else begin
				result_s5 <= scaled[COEFF_WIDTH-1:0];
				sat_s5    <= 1'b0;
			end
		end
	end

	assign result = result_s5;
	assign sat    = sat_s5;
endmodule
